// ----- hdl/wsdf_pkg.sv -----
package wsdf_pkg;

  // Frame kinds as reported on frame_kind
  localparam logic [2:0] KIND_CONT    = 3'd0;
  localparam logic [2:0] KIND_TEXT    = 3'd1;
  localparam logic [2:0] KIND_BINARY  = 3'd2;
  localparam logic [2:0] KIND_CLOSE   = 3'd3;
  localparam logic [2:0] KIND_PING    = 3'd4;
  localparam logic [2:0] KIND_PONG    = 3'd5;
  localparam logic [2:0] KIND_UNKNOWN = 3'd6;

  // Opcodes from the low nibble of the first header byte
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'ha;

  // Error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_TRUNC = 2'd1;
  localparam logic [1:0] ERR_LONG  = 2'd2;
  localparam logic [1:0] ERR_FRAG  = 2'd3;

  // Length field escapes and extension sizes
  localparam logic [6:0] LEN_EXT16    = 7'd126;
  localparam logic [6:0] LEN_EXT64    = 7'd127;
  localparam logic [3:0] EXT16_BYTES  = 4'd2;
  localparam logic [3:0] EXT64_BYTES  = 4'd8;
  localparam logic [3:0] KEY_BYTES    = 4'd4;

  localparam logic [31:0] MAX_LEN_RESET = 32'd4194304;

  // One result item
  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       frame_done;
    logic [2:0] frame_kind;
    logic       final_flag;
    logic       masked_flag;
    logic [1:0] error_code;
    logic       message_done;
  } wsdf_result_t;

  function automatic logic [2:0] kind_of(input logic [7:0] hdr);
    logic [2:0] k;
    case (hdr[3:0])
      OP_CONT:   k = KIND_CONT;
      OP_TEXT:   k = KIND_TEXT;
      OP_BINARY: k = KIND_BINARY;
      OP_CLOSE:  k = KIND_CLOSE;
      OP_PING:   k = KIND_PING;
      OP_PONG:   k = KIND_PONG;
      default:   k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

endpackage

// ----- hdl/wsdf_parser.sv -----
module wsdf_parser
  import wsdf_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   in_byte,
  input  logic         in_last,
  input  logic [31:0]  max_len,
  output logic         res_valid,
  output wsdf_result_t res
);

  localparam int CW = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

  localparam logic [2:0] PH_HDR1 = 3'd0;
  localparam logic [2:0] PH_HDR2 = 3'd1;
  localparam logic [2:0] PH_EXT  = 3'd2;
  localparam logic [2:0] PH_KEY  = 3'd3;
  localparam logic [2:0] PH_PAY  = 3'd4;

  logic [2:0]             phase, phase_next;
  logic [7:0]             first_header, first_header_next;
  logic [3:0]             ext_count, ext_count_next;
  logic [LENGTH_BITS-1:0] remaining, remaining_next;
  logic [31:0]            mask_key, mask_key_next;
  logic [1:0]             mask_pos, mask_pos_next;
  logic                   message_open, message_open_next;
  logic                   frame_masked, frame_masked_next;
  logic [1:0]             frame_error, frame_error_next;
  logic                   deliver, deliver_next;

  logic       len_known, hdr_done, done, bv;
  logic [7:0] pb, key_byte;
  logic [2:0] hk, sk;
  logic       fin;

  // Key byte for the current payload position, big-endian order
  always_comb begin
    case (mask_pos)
      2'd0:    key_byte = mask_key[31:24];
      2'd1:    key_byte = mask_key[23:16];
      2'd2:    key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  assign hk = kind_of(first_header);

  // Next state and result for one byte
  always_comb begin
    phase_next        = phase;
    first_header_next = first_header;
    ext_count_next    = ext_count;
    remaining_next    = remaining;
    mask_key_next     = mask_key;
    mask_pos_next     = mask_pos;
    message_open_next = message_open;
    frame_masked_next = frame_masked;
    frame_error_next  = frame_error;
    deliver_next      = deliver;
    len_known         = 1'b0;
    hdr_done          = 1'b0;
    done              = 1'b0;
    bv                = 1'b0;
    pb                = 8'd0;
    sk                = 3'd0;
    fin               = 1'b0;
    res               = '0;

    case (phase)
      PH_HDR2: begin
        frame_masked_next = in_byte[7];
        if (in_byte[6:0] == LEN_EXT16) begin
          ext_count_next = EXT16_BYTES;
          phase_next     = PH_EXT;
        end else if (in_byte[6:0] == LEN_EXT64) begin
          ext_count_next = EXT64_BYTES;
          phase_next     = PH_EXT;
        end else begin
          remaining_next = LENGTH_BITS'(in_byte[6:0]);
          len_known      = 1'b1;
        end
      end
      PH_EXT: begin
        // saturate once the length no longer fits
        if (remaining[LENGTH_BITS-1 -: 8] != 8'd0) begin
          remaining_next = '1;
        end else begin
          remaining_next = {remaining[LENGTH_BITS-9:0], in_byte};
        end
        ext_count_next = ext_count - 4'd1;
        if (ext_count == 4'd1) begin
          len_known = 1'b1;
        end
      end
      PH_KEY: begin
        mask_key_next  = {mask_key[23:0], in_byte};
        ext_count_next = ext_count - 4'd1;
        if (ext_count == 4'd1) begin
          hdr_done = 1'b1;
        end
      end
      PH_PAY: begin
        if (deliver) begin
          pb = in_byte ^ key_byte;
          bv = 1'b1;
        end
        mask_pos_next  = mask_pos + 2'd1;
        remaining_next = remaining - LENGTH_BITS'(1);
        if (remaining == LENGTH_BITS'(1)) begin
          done = 1'b1;
        end
      end
      default: begin
        first_header_next = in_byte;
        frame_masked_next = 1'b0;
        mask_key_next     = '0;
        mask_pos_next     = 2'd0;
        remaining_next    = '0;
        ext_count_next    = 4'd0;
        frame_error_next  = ERR_NONE;
        deliver_next      = 1'b0;
        phase_next        = PH_HDR2;
      end
    endcase

    // Length known: mask key next, or header is complete
    if (len_known) begin
      if (frame_masked_next) begin
        ext_count_next = KEY_BYTES;
        phase_next     = PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    // Header complete: classify the frame
    if (hdr_done) begin
      if (CW'(remaining_next) > CW'(max_len)) begin
        frame_error_next = ERR_LONG;
      end else if (hk == KIND_CONT && !message_open) begin
        frame_error_next = ERR_FRAG;
      end else if ((hk == KIND_TEXT || hk == KIND_BINARY) && message_open) begin
        frame_error_next = ERR_FRAG;
      end else begin
        frame_error_next = ERR_NONE;
      end
      deliver_next  = (frame_error_next == ERR_NONE) && (hk <= KIND_BINARY);
      mask_pos_next = 2'd0;
      if (remaining_next == '0) begin
        done = 1'b1;
      end else begin
        phase_next = PH_PAY;
      end
    end

    // Buffer ended mid-frame
    if (in_last && !done) begin
      frame_error_next = ERR_TRUNC;
      done             = 1'b1;
    end

    res.payload_byte = pb;
    res.byte_valid   = bv;

    // Frame summary and message tracking
    if (done) begin
      sk  = kind_of(first_header_next);
      fin = first_header_next[7];
      if (frame_error_next == ERR_NONE) begin
        if (sk == KIND_TEXT || sk == KIND_BINARY || sk == KIND_CONT) begin
          message_open_next = !fin;
        end
      end
      res.frame_done   = 1'b1;
      res.frame_kind   = sk;
      res.final_flag   = fin;
      res.masked_flag  = frame_masked_next;
      res.error_code   = frame_error_next;
      res.message_done = (frame_error_next == ERR_NONE) && fin && (sk != KIND_UNKNOWN);
      phase_next       = PH_HDR1;
      deliver_next     = 1'b0;
      frame_error_next = ERR_NONE;
    end
  end

  assign res_valid = done || bv;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR1;
      first_header <= 8'd0;
      ext_count    <= 4'd0;
      remaining    <= '0;
      mask_key     <= 32'd0;
      mask_pos     <= 2'd0;
      message_open <= 1'b0;
      frame_masked <= 1'b0;
      frame_error  <= ERR_NONE;
      deliver      <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      first_header <= first_header_next;
      ext_count    <= ext_count_next;
      remaining    <= remaining_next;
      mask_key     <= mask_key_next;
      mask_pos     <= mask_pos_next;
      message_open <= message_open_next;
      frame_masked <= frame_masked_next;
      frame_error  <= frame_error_next;
      deliver      <= deliver_next;
    end
  end

  // Payload phase always has bytes left
  a_pay_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAY |-> remaining != '0)
    else $error("payload phase with zero bytes left");

  // Header extension and key phases always have a count
  a_count_live: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_EXT || phase == PH_KEY) |-> ext_count != 4'd0)
    else $error("extension or key phase with zero count");

  // Delivery only happens for clean frames
  a_deliver_clean: assert property (@(posedge clk) disable iff (rst)
    deliver |-> frame_error == ERR_NONE && phase == PH_PAY)
    else $error("delivery outside a clean payload");

endmodule

// ----- hdl/wsdf_out_reg.sv -----
module wsdf_out_reg
  import wsdf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  wsdf_result_t din,
  output logic         can_load,
  output logic         out_valid,
  input  logic         out_ready,
  output wsdf_result_t dout
);

  // Refill whenever empty or being drained this cycle
  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      dout <= din;
    end
  end

endmodule

// ----- hdl/websocket_frame_deframer.sv -----
// WebSocket receive-side deframer.
// Input channel: in_valid/in_ready carry one received byte (in_byte) per item,
// with in_last marking the end of a received buffer. Output channel:
// out_valid/out_ready carry one result item: an unmasked data payload byte,
// a frame summary (kind, FIN, mask bit, error code, message end), or both
// when the last payload byte closes the frame. Header bytes, key bytes and
// payload of control, unknown or rejected frames produce no item unless they
// close a frame.
// Throughput: one byte per clock while the output does not stall; the parser
// state updates in the accept cycle and the result lands in a single output
// register. A result is visible in the cycle after its byte is accepted.
// Outside reset, in_ready drops only while the output register holds an item
// that the receiver has not taken; a stalled receiver thus holds off the input
// and nothing is lost or repeated.
// cfg_write loads cfg_data as the largest payload length accepted; write it
// only while the block is idle.
// Reset (rst, synchronous) holds in_ready low, returns the parser to the
// first header byte, closes any open message, empties the output register
// and sets the limit to 4194304.
module websocket_frame_deframer
  import wsdf_pkg::*;
#(
  parameter int LENGTH_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  payload_byte,
  output logic        byte_valid,
  output logic        frame_done,
  output logic [2:0]  frame_kind,
  output logic        final_flag,
  output logic        masked_flag,
  output logic [1:0]  error_code,
  output logic        message_done,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data
);

  logic [31:0]  max_payload_length;
  logic         step, res_valid, can_load;
  wsdf_result_t res, dout;

  // Length limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload_length <= MAX_LEN_RESET;
    end else if (cfg_write) begin
      max_payload_length <= cfg_data;
    end
  end

  assign in_ready = can_load && !rst;
  assign step     = in_valid && in_ready;

  wsdf_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .max_len  (max_payload_length),
    .res_valid(res_valid),
    .res      (res)
  );

  wsdf_out_reg u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (step && res_valid),
    .din      (res),
    .can_load (can_load),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .dout     (dout)
  );

  assign payload_byte = dout.payload_byte;
  assign byte_valid   = dout.byte_valid;
  assign frame_done   = dout.frame_done;
  assign frame_kind   = dout.frame_kind;
  assign final_flag   = dout.final_flag;
  assign masked_flag  = dout.masked_flag;
  assign error_code   = dout.error_code;
  assign message_done = dout.message_done;

  // Every item carries a byte or a summary
  a_item_content: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_valid || frame_done)
    else $error("empty result item");

  // Summary fields are zero outside a frame end
  a_summary_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_done |-> frame_kind == 3'd0 && !final_flag && !masked_flag
      && error_code == ERR_NONE && !message_done)
    else $error("summary fields set without frame end");

  // Message end only on a clean final frame
  a_msg_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_done |-> final_flag && error_code == ERR_NONE
      && frame_kind != KIND_UNKNOWN)
    else $error("message end on a bad frame");

  // Payload byte is zero when it carries nothing
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> payload_byte == 8'd0)
    else $error("stray payload byte");

endmodule
